// ===== sv/fdiv_pkg.sv =====
// Shared types and constants for the frame rate divisor selector.
package fdiv_pkg;

  localparam int unsigned RateWidth = 10;
  localparam int unsigned DiscWidth = 8;

  typedef struct packed {
    logic [RateWidth-1:0] refresh_rate;
    logic [RateWidth-1:0] preferred_rate;
    logic                 range_valid;
    logic [DiscWidth-1:0] rate_discount;
  } fdiv_in_t;

  typedef struct packed {
    logic [RateWidth-1:0] drawing_rate;
    logic                 discount_applied;
  } fdiv_out_t;

  typedef struct packed {
    logic                 start;
    logic [RateWidth-1:0] dividend;
    logic [RateWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [RateWidth-1:0] quotient;
    logic [RateWidth-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== sv/frame_rate_divisor_select.sv =====
// Top level of the frame rate divisor selector: sequencer around a shared divider.
//
// Input transactions carry a refresh rate, a preferred rate, a range-valid flag and
// a rate discount; each produces exactly one output transaction with the drawing
// rate and a flag that tells whether the discounted rate was taken.
// Both channels use valid and stall. The block stalls its input from the cycle
// after a transaction is accepted until the result has been taken downstream.
// All arithmetic runs through one restoring divider; each division is launched
// by a start request. An optional division forms the discounted candidate, then
// each rate pick does one division for refresh/preferred and one division per
// divisor tried while counting down. Trivial cases need no division; the worst
// case is a prime refresh rate of 1021 with a preferred rate of four and a
// discount of two.
// The result is held in an output register; while the receiver stalls it stays
// there unchanged and no new input is taken.
// Reset returns the sequencer to idle and drops output valid; no state survives
// between transactions.
module frame_rate_divisor_select (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fdiv_pkg::fdiv_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fdiv_pkg::fdiv_out_t out_data_o
);

  localparam int unsigned W = fdiv_pkg::RateWidth;
  localparam int unsigned DW = fdiv_pkg::DiscWidth;
  localparam logic [DW-1:0] MinDiscount = DW'(2);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAND,
    S_CAND_WAIT,
    S_PSTART,
    S_PQUO,
    S_PCHK,
    S_PREM,
    S_PEND,
    S_OUT
  } state_e;

  state_e              state_q;
  logic [W-1:0]        refresh_q;
  logic [W-1:0]        pref_q;
  logic                valid_q;
  logic [DW-1:0]       disc_q;
  logic [W-1:0]        p_q;
  logic                v_q;
  logic                pass_q;
  logic [W-1:0]        cand_q;
  logic [W-1:0]        d_q;
  logic [W-1:0]        r_q;
  logic                out_valid_q;
  fdiv_pkg::fdiv_out_t out_data_q;

  fdiv_pkg::div_req_t  div_req;
  fdiv_pkg::div_rsp_t  div_rsp;

  logic                disc_on;
  logic [W-1:0]        base_rate;
  logic                pick_trivial;

  always_comb begin
    disc_on      = (disc_q >= MinDiscount) && !(pref_q == '0 && refresh_q == '0);
    base_rate    = (pref_q == '0 || pref_q > refresh_q) ? refresh_q : pref_q;
    pick_trivial = (refresh_q == '0) || (p_q == '0) || !v_q || (p_q > refresh_q);
    div_req      = '0;
    unique case (state_q)
      S_CAND: begin
        div_req.start    = disc_on;
        div_req.dividend = base_rate;
        div_req.divisor  = W'(disc_q);
      end
      S_PSTART: begin
        div_req.start    = !pick_trivial;
        div_req.dividend = refresh_q;
        div_req.divisor  = p_q;
      end
      S_PCHK: begin
        div_req.start    = 1'b1;
        div_req.dividend = refresh_q;
        div_req.divisor  = d_q;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  fdiv_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      refresh_q   <= '0;
      pref_q      <= '0;
      valid_q     <= 1'b0;
      disc_q      <= '0;
      p_q         <= '0;
      v_q         <= 1'b0;
      pass_q      <= 1'b0;
      cand_q      <= '0;
      d_q         <= '0;
      r_q         <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            refresh_q <= in_data_i.refresh_rate;
            pref_q    <= in_data_i.preferred_rate;
            valid_q   <= in_data_i.range_valid;
            disc_q    <= in_data_i.rate_discount;
            p_q       <= in_data_i.preferred_rate;
            v_q       <= in_data_i.range_valid;
            pass_q    <= 1'b0;
            state_q   <= S_CAND;
          end
        end
        S_CAND: begin
          state_q <= disc_on ? S_CAND_WAIT : S_PSTART;
        end
        S_CAND_WAIT: begin
          if (div_rsp.done) begin
            cand_q  <= div_rsp.quotient;
            p_q     <= div_rsp.quotient;
            v_q     <= 1'b1;
            pass_q  <= 1'b1;
            state_q <= S_PSTART;
          end
        end
        S_PSTART: begin
          priority if (refresh_q == '0 || p_q == '0) begin
            r_q     <= '0;
            state_q <= S_PEND;
          end else if (!v_q || p_q > refresh_q) begin
            r_q     <= refresh_q;
            state_q <= S_PEND;
          end else begin
            state_q <= S_PQUO;
          end
        end
        S_PQUO: begin
          if (div_rsp.done) begin
            d_q     <= div_rsp.quotient;
            state_q <= S_PCHK;
          end
        end
        S_PCHK: begin
          state_q <= S_PREM;
        end
        S_PREM: begin
          if (div_rsp.done) begin
            if (d_q > W'(1) && div_rsp.remainder != '0) begin
              d_q     <= d_q - 1'b1;
              state_q <= S_PCHK;
            end else begin
              r_q     <= div_rsp.quotient;
              state_q <= S_PEND;
            end
          end
        end
        S_PEND: begin
          if (pass_q && r_q == cand_q) begin
            out_data_q.drawing_rate     <= cand_q;
            out_data_q.discount_applied <= 1'b1;
            out_valid_q                 <= 1'b1;
            state_q                     <= S_OUT;
          end else if (pass_q) begin
            p_q     <= pref_q;
            v_q     <= valid_q;
            pass_q  <= 1'b0;
            state_q <= S_PSTART;
          end else begin
            out_data_q.drawing_rate     <= r_q;
            out_data_q.discount_applied <= 1'b0;
            out_valid_q                 <= 1'b1;
            state_q                     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/fdiv_divider.sv =====
// Restoring shift-subtract divider that produces one quotient bit per cycle while busy.
module fdiv_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fdiv_pkg::div_req_t req_i,
  output fdiv_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W = fdiv_pkg::RateWidth;
  localparam int unsigned CntW = $clog2(W);
  localparam logic [CntW-1:0] LastCnt = CntW'(W - 1);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q;
  logic [W-1:0]    quo_q;
  logic [W-1:0]    den_q;

  logic [W:0]      shifted;
  logic            ge;
  logic [W:0]      diff;
  logic [W-1:0]    rem_d;
  logic [W-1:0]    quo_d;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, den_q};
    ge      = (shifted >= {1'b0, den_q});
    rem_d   = ge ? diff[W-1:0] : shifted[W-1:0];
    quo_d   = {quo_q[W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule
